// File: hw/rtl/alag_pkg.sv
package alag_pkg;

  localparam int XW = 24;
  localparam int VW = 64;
  localparam int DW = 3;
  localparam int OW = 4;

  // Configuration register indexes
  localparam logic CFG_DEGREE = 1'b0;
  localparam logic CFG_ORDER  = 1'b1;

  localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};

  // Word handed from one cell to the next
  typedef struct packed {
    logic                 vld;
    logic [XW-1:0]        x;
    logic [OW-1:0]        m;
    logic [3:0]           n;
    logic signed [VW-1:0] prev;
    logic signed [VW-1:0] cur;
    logic                 ovf;
  } alag_word_t;

  // Operation phases inside a cell
  typedef enum logic [3:0] {
    PH_IDLE, PH_M1_LO, PH_M1_HI, PH_M1_RES, PH_M2_LO, PH_M2_HI, PH_M2_RES,
    PH_SUB, PH_DIV, PH_DONE
  } alag_phase_t;

endpackage

// File: hw/rtl/alag_cell.sv
// One recurrence step k = KIDX: two split multiplies, a subtract and a divide by k.
module alag_cell #(
  parameter int KIDX = 2,
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  alag_pkg::alag_word_t in_w,
  output alag_pkg::alag_word_t out_w
);
  import alag_pkg::*;

  localparam int MW    = 32;           // multiplier operand width
  localparam int PW    = VW + MW;      // full product width
  localparam int CW    = 7;            // recurrence coefficient width
  localparam int DIG   = 16;           // quotient bits per divide step
  localparam int RW    = 4;            // remainder width, k below 16
  localparam int DVW   = DIG + RW;
  localparam int RS    = 24;           // reciprocal scale, exact for DVW-bit dividends
  localparam int RCW   = 24;
  localparam int RECIP = ((1 << RS) + KIDX - 1) / KIDX;
  localparam int NSTEP = VW / DIG;

  alag_phase_t ph_r, ph_nxt;
  alag_word_t  w_r;
  alag_word_t  out_r, out_nxt;
  logic [MW-1:0] ua1_r, ua2_r;
  logic [VW-1:0] ub1_r, ub2_r;
  logic          neg1_r, neg2_r;
  logic [VW-1:0] acc_r;
  logic [PW-1:0] prod_r;
  logic signed [VW-1:0] p1_r, p2_r;
  logic          ovf_r;
  logic [VW-1:0] q_r;
  logic [RW-1:0] rem_r;
  logic [1:0]    cnt_r;
  logic          neg_r;

  logic          act_in, active;
  logic [CW-1:0] c1, c2;
  logic [VW-1:0] a1, a1_mag, a2, cur_mag, prev_mag;
  logic [MW-1:0] ma, mb;
  logic [VW-1:0] mprod;
  logic          mneg, msat;
  logic [VW-1:0] pmag;
  logic signed [VW-1:0] mres;
  logic [VW:0]   dwide;
  logic          dsat;
  logic [VW-1:0] dval, dmag;
  logic [DVW-1:0] dv, dqk;
  logic [DVW+RCW-1:0] dprod;
  logic [DIG-1:0] dq;

  assign act_in = (4'(KIDX) <= in_w.n);
  assign active = (4'(KIDX) <= w_r.n);

  // operand magnitudes and signs from the incoming word
  always_comb begin
    c1       = CW'(2 * KIDX - 1) + CW'(in_w.m);
    c2       = CW'(KIDX - 1) + CW'(in_w.m);
    a1       = (VW'(c1) << FRAC_BITS) - VW'(in_w.x);
    a1_mag   = a1[VW-1] ? -a1 : a1;
    a2       = VW'(c2) << FRAC_BITS;
    cur_mag  = in_w.cur[VW-1] ? VW'(-in_w.cur) : VW'(in_w.cur);
    prev_mag = in_w.prev[VW-1] ? VW'(-in_w.prev) : VW'(in_w.prev);
  end

  // shared 32x32 multiplier, one half of the wide operand per cycle
  always_comb begin
    case (ph_r)
      PH_M1_LO: begin
        ma = ua1_r;
        mb = ub1_r[MW-1:0];
      end
      PH_M1_HI: begin
        ma = ua1_r;
        mb = ub1_r[VW-1:MW];
      end
      PH_M2_LO: begin
        ma = ua2_r;
        mb = ub2_r[MW-1:0];
      end
      PH_M2_HI: begin
        ma = ua2_r;
        mb = ub2_r[VW-1:MW];
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
    mprod = VW'(ma) * VW'(mb);
  end

  // drop fraction bits, saturate and restore the sign
  always_comb begin
    mneg = (ph_r == PH_M1_RES) ? neg1_r : neg2_r;
    pmag = prod_r[FRAC_BITS +: VW];
    msat = (prod_r[PW-1:FRAC_BITS+VW] != '0) ||
           (mneg ? (pmag > unsigned'(VMIN)) : pmag[VW-1]);
    if (msat)      mres = mneg ? VMIN : VMAX;
    else if (mneg) mres = signed'(-pmag);
    else           mres = signed'(pmag);
  end

  // saturated difference and its magnitude
  always_comb begin
    dwide = {p1_r[VW-1], p1_r} - {p2_r[VW-1], p2_r};
    dsat  = (dwide[VW] != dwide[VW-1]);
    if (dsat) dval = dwide[VW] ? unsigned'(VMIN) : unsigned'(VMAX);
    else      dval = dwide[VW-1:0];
    dmag = dval[VW-1] ? -dval : dval;
  end

  // one 16-bit quotient digit of the divide by k, by reciprocal multiply
  always_comb begin
    dv    = {rem_r, q_r[VW-1 -: DIG]};
    dprod = (DVW+RCW)'(dv) * (DVW+RCW)'(RECIP);
    dq    = dprod[RS +: DIG];
    dqk   = DVW'(dq) * DVW'(KIDX);
  end

  always_comb begin
    ph_nxt = ph_r;
    case (ph_r)
      PH_IDLE:   if (in_w.vld) ph_nxt = act_in ? PH_M1_LO : PH_DONE;
      PH_M1_LO:  ph_nxt = PH_M1_HI;
      PH_M1_HI:  ph_nxt = PH_M1_RES;
      PH_M1_RES: ph_nxt = PH_M2_LO;
      PH_M2_LO:  ph_nxt = PH_M2_HI;
      PH_M2_HI:  ph_nxt = PH_M2_RES;
      PH_M2_RES: ph_nxt = PH_SUB;
      PH_SUB:    ph_nxt = PH_DIV;
      PH_DIV:    if (cnt_r == 2'(NSTEP - 1)) ph_nxt = PH_DONE;
      PH_DONE:   ph_nxt = PH_IDLE;
      default:   ph_nxt = PH_IDLE;
    endcase
  end

  // word handed on; an idle cell passes its word through untouched
  always_comb begin
    out_nxt     = w_r;
    out_nxt.vld = (ph_r == PH_DONE);
    if (active) begin
      out_nxt.prev = w_r.cur;
      out_nxt.cur  = neg_r ? signed'(-q_r) : signed'(q_r);
      out_nxt.ovf  = ovf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r  <= PH_IDLE;
      out_r <= '0;
    end else begin
      ph_r  <= ph_nxt;
      out_r <= out_nxt;
      case (ph_r)
        PH_IDLE: begin
          w_r    <= in_w;
          ovf_r  <= in_w.ovf;
          ua1_r  <= a1_mag[MW-1:0];
          ua2_r  <= a2[MW-1:0];
          ub1_r  <= cur_mag;
          ub2_r  <= prev_mag;
          neg1_r <= a1[VW-1] ^ in_w.cur[VW-1];
          neg2_r <= in_w.prev[VW-1];
        end
        PH_M1_LO, PH_M2_LO: acc_r <= mprod;
        PH_M1_HI, PH_M2_HI: prod_r <= {mprod, MW'(0)} + PW'(acc_r);
        PH_M1_RES: begin
          p1_r  <= mres;
          ovf_r <= ovf_r | msat;
        end
        PH_M2_RES: begin
          p2_r  <= mres;
          ovf_r <= ovf_r | msat;
        end
        PH_SUB: begin
          q_r   <= dmag;
          neg_r <= dval[VW-1];
          ovf_r <= ovf_r | dsat;
          rem_r <= '0;
          cnt_r <= '0;
        end
        PH_DIV: begin
          q_r   <= {q_r[VW-DIG-1:0], dq};
          rem_r <= RW'(dv - dqk);
          cnt_r <= cnt_r + 2'd1;
        end
        default: ;
      endcase
    end
  end

  assign out_w = out_r;

endmodule

// File: hw/rtl/associated_laguerre_eval.sv
// One word runs through a chain of cells for recurrence steps k = 2..MAX_DEGREE;
// a cell with k above the degree n is idle, and n is clamped to MAX_DEGREE.
// Each active cell runs two split multiplies, a subtract and four
// reciprocal divide digits; an idle cell passes the word on.
// A new word is accepted only while busy is low; busy is high while a word runs.
// Reset: synchronous rst_n clears degree and order; out_valid pulses, no stall.
module associated_laguerre_eval #(
  parameter int MAX_DEGREE = 7,
  parameter int FRAC_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [alag_pkg::XW-1:0]       in_arg_x,
  output logic                          out_valid,
  output logic signed [alag_pkg::VW-1:0] out_value,
  output logic                          out_overflow,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [alag_pkg::OW-1:0]       cfg_data
);
  import alag_pkg::*;

  localparam int NC = (MAX_DEGREE > 1) ? MAX_DEGREE - 1 : 1;

  logic [DW-1:0] degree_r;
  logic [OW-1:0] order_r;
  logic          busy_r;
  alag_word_t    link [NC+1];
  alag_word_t    head_r;
  logic [3:0]    n_eff;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      degree_r <= '0;
      order_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DEGREE: degree_r <= cfg_data[DW-1:0];
        CFG_ORDER:  order_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign n_eff = (4'(degree_r) > 4'(MAX_DEGREE)) ? 4'(MAX_DEGREE) : 4'(degree_r);

  // seed word: L0 and L1
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      head_r.vld <= 1'b0;
    end else begin
      head_r.vld <= start && !busy_r;
      if (start && !busy_r) begin
        busy_r      <= 1'b1;
        head_r.x    <= in_arg_x;
        head_r.m    <= order_r;
        head_r.n    <= n_eff;
        head_r.ovf  <= 1'b0;
        head_r.prev <= VW'(64'sd1 <<< FRAC_BITS);
        head_r.cur  <= (n_eff == 4'd0) ? VW'(64'sd1 <<< FRAC_BITS) :
                       (VW'({1'b0, 5'(order_r) + 5'd1}) <<< FRAC_BITS)
                       - VW'({1'b0, in_arg_x});
      end else if (link[NC].vld) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign link[0] = head_r;

  genvar g;
  generate
    for (g = 0; g < NC; g++) begin : g_cell
      alag_cell #(.KIDX(g + 2), .FRAC_BITS(FRAC_BITS)) u_cell (
        .clk(clk), .rst_n(rst_n), .in_w(link[g]), .out_w(link[g+1])
      );
    end
  endgenerate

  assign busy         = busy_r;
  assign out_valid    = link[NC].vld;
  assign out_value    = link[NC].cur;
  assign out_overflow = link[NC].ovf;

endmodule

// File: sim/laguerre_checker.sv
module laguerre_checker
  import alag_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 busy,
  input  logic [XW-1:0]        arg_x,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [OW-1:0]        cfg_data,
  input  logic                 out_valid,
  input  logic signed [VW-1:0] out_value,
  input  logic                 out_overflow,
  output int                   fail_count,
  output int                   pending
);

  localparam int FRAC = 16;

  typedef struct packed {
    logic signed [VW-1:0] value;
    logic                 overflow;
  } lag_result_t;

  logic [DW-1:0] degree_q;
  logic [OW-1:0] order_q;
  lag_result_t   lag_expected_q[$];

  // trunc(a*b / 2^FRAC), saturated
  function automatic longint mul_frac_sat(input longint a, input longint b, inout logic ovf);
    logic         neg;
    logic [63:0]  ua, ub, mag, lim;
    logic [127:0] prod;
    neg  = a[63] ^ b[63];
    ua   = a[63] ? 64'(-a) : 64'(a);
    ub   = b[63] ? 64'(-b) : 64'(b);
    prod = {64'b0, ua} * {64'b0, ub};
    lim  = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    if (prod[127:64+FRAC] != 0) begin
      ovf = 1'b1;
      return neg ? VMIN : VMAX;
    end
    mag = prod[64+FRAC-1:FRAC];
    if (mag > lim) begin
      ovf = 1'b1;
      return neg ? VMIN : VMAX;
    end
    return neg ? longint'(-mag) : longint'(mag);
  endfunction

  function automatic longint sub_sat(input longint a, input longint b, inout logic ovf);
    logic signed [64:0] d;
    d = {a[63], a} - {b[63], b};
    if (d > 65'sh0_7FFF_FFFF_FFFF_FFFF) begin
      ovf = 1'b1;
      return VMAX;
    end
    if (d < -65'sh0_8000_0000_0000_0000) begin
      ovf = 1'b1;
      return VMIN;
    end
    return longint'(d[63:0]);
  endfunction

  // L_n^(m)(x) by the three-term recurrence
  function automatic lag_result_t laguerre_value(input logic [XW-1:0] x_in,
                                                  input logic [DW-1:0] n,
                                                  input logic [OW-1:0] m_in);
    longint      x, m, prev, cur, a, p1, p2, d;
    logic        ovf;
    lag_result_t r;
    x    = longint'({40'b0, x_in});
    m    = longint'(m_in);
    ovf  = 1'b0;
    prev = 64'sd1 <<< FRAC;
    cur  = ((1 + m) <<< FRAC) - x;
    if (n == 0) cur = 64'sd1 <<< FRAC;
    for (longint k = 2; k <= n; k++) begin
      a    = ((2 * k - 1 + m) <<< FRAC) - x;
      p1   = mul_frac_sat(a, cur, ovf);
      p2   = mul_frac_sat((k - 1 + m) <<< FRAC, prev, ovf);
      d    = sub_sat(p1, p2, ovf);
      prev = cur;
      cur  = d / k;
    end
    r.value    = cur;
    r.overflow = ovf;
    return r;
  endfunction

  assign pending = lag_expected_q.size();

  always @(posedge clk) begin
    lag_result_t exp_w;
    if (!rst_n) begin
      degree_q <= '0;
      order_q  <= '0;
      lag_expected_q.delete();
      fail_count <= 0;
    end else begin
      // register writes
      if (cfg_we) begin
        if (cfg_index == CFG_DEGREE) degree_q <= cfg_data[DW-1:0];
        else if (cfg_index == CFG_ORDER) order_q <= cfg_data;
      end
      // accepted argument word
      if (start && !busy)
        lag_expected_q.insert(lag_expected_q.size(),
                              laguerre_value(arg_x, degree_q, order_q));
      // result word
      if (out_valid) begin
        if (lag_expected_q.size() == 0) begin
          $display("%0t: unexpected result value=%0d ovf=%0b", $time, out_value, out_overflow);
          fail_count <= fail_count + 1;
        end else begin
          exp_w = lag_expected_q.pop_front();
          if (out_value !== exp_w.value || out_overflow !== exp_w.overflow) begin
            $display("%0t: mismatch expected value=%0d ovf=%0b actual value=%0d ovf=%0b",
                     $time, exp_w.value, exp_w.overflow, out_value, out_overflow);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// File: sim/tb_associated_laguerre_eval.sv
module tb_associated_laguerre_eval;
  import alag_pkg::*;

  localparam int LATENCY = 1 + 2 * 6 + 11 * 6;
  localparam int N_PHASE = 12;
  localparam int N_RAND  = 93;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [XW-1:0]        in_arg_x = '0;
  logic                 out_valid;
  logic signed [VW-1:0] out_value;
  logic                 out_overflow;
  logic                 cfg_we = 1'b0;
  logic                 cfg_index = CFG_DEGREE;
  logic [OW-1:0]        cfg_data = '0;
  int                   fail_count;
  int                   pending;

  associated_laguerre_eval dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_arg_x(in_arg_x),
    .out_valid(out_valid), .out_value(out_value), .out_overflow(out_overflow),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  laguerre_checker u_chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .arg_x(in_arg_x),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_value(out_value), .out_overflow(out_overflow),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit
  initial begin
    #(12 * 3_000_000);
    $display("*** FAILED ***");
    $finish;
  end

  // present one argument word and hold it until taken
  task automatic send_arg(input logic [XW-1:0] x);
    start    <= 1'b1;
    in_arg_x <= x;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
  endtask

  // degree gets a random bit 3, which the block must drop
  task automatic set_poly(input logic [2:0] n, input logic [3:0] m);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_DEGREE;
    cfg_data  <= {1'($urandom_range(0, 1)), n};
    @(posedge clk);
    cfg_index <= CFG_ORDER;
    cfg_data  <= m;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  logic [XW-1:0] corner_x[7] = '{24'h000000, 24'hFFFFFF, 24'h000001, 24'h800000,
                                 24'h010000, 24'h7FFFFF, 24'h0F0000};
  logic [2:0]    ph_deg[N_PHASE] = '{3'd0, 3'd7, 3'd7, 3'd1, 3'd0, 3'd2,
                                     3'd3, 3'd7, 3'd5, 3'd4, 3'd6, 3'd7};
  logic [3:0]    ph_ord[N_PHASE] = '{4'd0, 4'd15, 4'd0, 4'd15, 4'd15, 4'd0,
                                     4'd7, 4'd15, 4'd3, 4'd9, 4'd12, 4'd1};

  initial begin
    int burst;
    logic [XW-1:0] x;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int p = 0; p < N_PHASE; p++) begin
      // first phase runs on reset values
      if (p != 0) begin
        drain();
        set_poly(ph_deg[p], ph_ord[p]);
      end
      if (p >= 1 && p <= 3)
        foreach (corner_x[i]) send_arg(corner_x[i]);
      for (int i = 0; i < N_RAND; ) begin
        burst = $urandom_range(1, 8);
        for (int b = 0; b < burst && i < N_RAND; b++, i++) begin
          case ($urandom_range(0, 7))
            0:       x = XW'($urandom_range(0, 3));
            1:       x = 24'hFFFFFF - XW'($urandom_range(0, 3));
            2:       x = {8'($urandom_range(0, 255)), 16'h0};
            default: x = XW'($urandom);
          endcase
          send_arg(x);
        end
        start <= 1'b0;
        if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 500)) @(posedge clk);
        else @(posedge clk);
      end
    end
    drain();
    repeat (LATENCY + 20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
